@@ hdl/ggw_pkg.sv @@
// ----------------------------------------------------------------------------
// Greedy word wrap package
// Shared character type, character codes, register indexes and the control
// record that drives one cell of the word buffer chain.
// ----------------------------------------------------------------------------
`default_nettype none

package ggw_pkg;

   typedef logic [7:0] char_type;

   localparam char_type CHAR_SPACE = 8'd32;
   localparam char_type CHAR_TAB   = 8'd9;
   localparam char_type CHAR_NL    = 8'd10;

   localparam logic [7:0] COL_SAT = 8'd255;

   localparam int LINE_LIMIT_W = 7;
   localparam int TAB_WIDTH_W  = 4;
   localparam int CSR_DATA_W   = 7;

   localparam logic CSR_LINE_LIMIT = 1'b0;
   localparam logic CSR_TAB_WIDTH  = 1'b1;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ hdl/ggw_cell.sv @@
// ----------------------------------------------------------------------------
// Word buffer cell
// Holds one character of the buffered word. It loads a new character when
// selected and takes its neighbor's character when the chain shifts out.
// ----------------------------------------------------------------------------
`default_nettype none

module ggw_cell (
   input  wire                    clock,
   input  ggw_pkg::cell_ctrl_type ctrl,
   input  ggw_pkg::char_type      load_data,
   input  ggw_pkg::char_type      next_data,
   output ggw_pkg::char_type      data_out
);
   import ggw_pkg::*;

   char_type data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         data_ff <= next_data;
      end else if (ctrl.load) begin
         data_ff <= load_data;
      end
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire

@@ hdl/greedy_word_wrap_stream.sv @@
// ----------------------------------------------------------------------------
// Greedy word wrap stream
// Buffers each word in a chain of character cells and releases it, with its
// delimiter, on a new line when it would overrun the configured width.
// ----------------------------------------------------------------------------
//   channel  direction  payload
//   req_     in         tdata = char_in
//   rsp_     out        tdata = char_out, tlast = last_of_run
//   csr_     in         index 0 line_limit, 1 tab_width
//
// A word character or a dropped delimiter is taken in the idle phase; a
// newline outside a word goes out through PH_POST_NL. A delimiter that
// ends a word holds req_tready low while an optional wrap newline, the
// word (shifted out of the cell chain through the output register, one
// character per cycle) and the delimiter go out. A stalled rsp_tready holds
// the chain in place. Reset is synchronous; the cell contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_word_wrap_stream #(
   parameter int WORD_MAX = 32
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_tvalid,
   output logic                      req_tready,
   input  ggw_pkg::char_type         req_tdata,    // [7:0] char_in
   output logic                      rsp_tvalid,
   input  wire                       rsp_tready,
   output ggw_pkg::char_type         rsp_tdata,    // [7:0] char_out
   output logic                      rsp_tlast,
   input  wire                       csr_we,
   input  wire                       csr_index,
   input  wire [ggw_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ggw_pkg::*;

   localparam int CNT_W = $clog2(WORD_MAX + 1);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_PRE_NL  = 3'd1;
   localparam logic [2:0] PH_WORD    = 3'd2;
   localparam logic [2:0] PH_DELIM   = 3'd3;
   localparam logic [2:0] PH_POST_NL = 3'd4;

   logic [2:0]             phase_ff, phase_in;
   char_type               delim_ff, delim_in;
   logic [CNT_W-1:0]       remain_ff, remain_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   inside_ff, inside_in;
   logic [7:0]             column_ff, column_in;
   logic [LINE_LIMIT_W-1:0] line_limit_ff;
   logic [TAB_WIDTH_W-1:0] tab_width_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   char_type               rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic          req_fire, out_free, is_delim, is_tab, is_nl;
   logic          emit, shift, write_en, wrap;
   logic [CNT_W-1:0] wr_idx;
   logic [8:0]    tab_sum, len, wrap_sum, new_sum;
   logic [7:0]    col_tab, col_base;
   char_type      cell_data [WORD_MAX];

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign is_tab   = (req_tdata == CHAR_TAB);
   assign is_nl    = (req_tdata == CHAR_NL);
   assign is_delim = (req_tdata == CHAR_SPACE) || is_tab || is_nl;

   assign tab_sum  = {1'b0, column_ff} + 9'(tab_width_ff);
   assign col_tab  = !is_tab ? column_ff :
                     (tab_sum > 9'(COL_SAT)) ? COL_SAT : tab_sum[7:0];
   assign len      = 9'(count_ff) + 9'd1;
   assign wrap_sum = {1'b0, col_tab} + len;
   assign wrap     = wrap_sum > 9'(line_limit_ff);
   assign col_base = wrap ? 8'd0 : col_tab;
   assign new_sum  = {1'b0, col_base} + len;

   assign write_en = req_fire && !is_delim &&
                     (!inside_ff || (count_ff < CNT_W'(WORD_MAX)));
   assign wr_idx   = inside_ff ? count_ff : '0;
   assign shift    = (phase_ff == PH_WORD) && out_free;

   genvar gi;
   generate
      for (gi = 0; gi < WORD_MAX; gi++) begin : g_cell
         cell_ctrl_type ctrl;
         char_type      next_data;
         assign ctrl.shift = shift;
         assign ctrl.load  = write_en && (wr_idx == CNT_W'(gi));
         if (gi == WORD_MAX - 1) begin : g_tail
            assign next_data = '0;
         end else begin : g_link
            assign next_data = cell_data[gi + 1];
         end
         ggw_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .load_data (req_tdata),
            .next_data (next_data),
            .data_out  (cell_data[gi])
         );
      end
   endgenerate

   always_comb begin
      phase_in    = phase_ff;
      delim_in    = delim_ff;
      remain_in   = remain_ff;
      count_in    = count_ff;
      inside_in   = inside_ff;
      column_in   = column_ff;
      emit        = 1'b0;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;

      case (phase_ff)
         PH_IDLE: begin
            if (req_fire) begin
               if (!is_delim) begin
                  inside_in = 1'b1;
                  if (write_en) begin
                     count_in = wr_idx + CNT_W'(1);
                  end
               end else if (inside_ff) begin
                  delim_in  = req_tdata;
                  remain_in = count_ff;
                  inside_in = 1'b0;
                  count_in  = '0;
                  if (is_nl) begin
                     column_in = 8'd0;
                  end else begin
                     column_in = (new_sum > 9'(COL_SAT)) ? COL_SAT : new_sum[7:0];
                  end
                  if (wrap) begin
                     phase_in = PH_PRE_NL;
                  end else if (count_ff != '0) begin
                     phase_in = PH_WORD;
                  end else begin
                     phase_in = PH_DELIM;
                  end
               end else if (is_nl) begin
                  column_in = 8'd0;
                  phase_in  = PH_POST_NL;
               end
            end
         end
         PH_PRE_NL: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_data_in = CHAR_NL;
               rsp_last_in = 1'b0;
               phase_in    = (remain_ff != '0) ? PH_WORD : PH_DELIM;
            end
         end
         PH_WORD: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_data_in = cell_data[0];
               rsp_last_in = 1'b0;
               remain_in   = remain_ff - CNT_W'(1);
               if (remain_ff == CNT_W'(1)) begin
                  phase_in = PH_DELIM;
               end
            end
         end
         PH_DELIM: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_data_in = delim_ff;
               rsp_last_in = (delim_ff != CHAR_NL);
               phase_in    = (delim_ff == CHAR_NL) ? PH_POST_NL : PH_IDLE;
            end
         end
         PH_POST_NL: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_data_in = CHAR_NL;
               rsp_last_in = 1'b1;
               phase_in    = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         remain_ff     <= '0;
         count_ff      <= '0;
         inside_ff     <= 1'b0;
         column_ff     <= 8'd0;
         line_limit_ff <= LINE_LIMIT_W'(50);
         tab_width_ff  <= TAB_WIDTH_W'(4);
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         remain_ff    <= remain_in;
         count_ff     <= count_in;
         inside_ff    <= inside_in;
         column_ff    <= column_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && (csr_index == CSR_LINE_LIMIT)) begin
            line_limit_ff <= csr_wdata[LINE_LIMIT_W-1:0];
         end
         if (csr_we && (csr_index == CSR_TAB_WIDTH)) begin
            tab_width_ff <= csr_wdata[TAB_WIDTH_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      delim_ff    <= delim_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (phase_ff == PH_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WORD_MAX))
      else $error("word count beyond buffer depth");

   a_word_nonempty: assert property (@(posedge clock) disable iff (reset)
      inside_ff |-> (count_ff != '0))
      else $error("open word holds no characters");

   a_flush_remain: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_WORD) |-> (remain_ff != '0))
      else $error("word flush with nothing left");

   a_flush_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_delim && inside_ff) |=> (phase_ff != PH_IDLE))
      else $error("ended word did not start a flush");

endmodule

`default_nettype wire
